// File: hdl/grid_diffusion_relaxation_macros.svh
// Assertion macros used by the checker file of the diffusion relaxation block.
// Depends on nothing; the including module provides clk and rst_n.
`ifndef GRID_DIFFUSION_RELAXATION_MACROS_SVH
`define GRID_DIFFUSION_RELAXATION_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define GDR_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define GDR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: hdl/gdr_pkg.sv
// Shared types and constants of the grid diffusion relaxation block.
// Depends on nothing; used by the top level, the update pipeline and the checker.
package gdr_pkg;

  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int FRAC_BITS  = 16;
  localparam int NUM_BITS   = 48;
  localparam int MAX_SWEEPS = 64;

  localparam logic [1:0] REQ_LOAD = 2'd0;
  localparam logic [1:0] REQ_RUN  = 2'd1;
  localparam logic [1:0] REQ_READ = 2'd2;

  localparam logic [2:0] REG_COEF_A     = 3'd0;
  localparam logic [2:0] REG_COEF_RECIP = 3'd1;
  localparam logic [2:0] REG_SWEEPS     = 3'd2;
  localparam logic [2:0] REG_MODE       = 3'd3;
  localparam logic [2:0] REG_WIDTH      = 3'd4;
  localparam logic [2:0] REG_HEIGHT     = 3'd5;

  localparam logic [1:0] MODE_NEG_LR = 2'd1;
  localparam logic [1:0] MODE_NEG_TB = 2'd2;

  typedef struct packed {
    logic [31:0] a;
    logic [16:0] rc;
  } coef_t;

endpackage

// File: hdl/grid_diffusion_relaxation.sv
// Top level of the grid diffusion relaxation block: stores, sweep sequencer, config.
// Depends on gdr_pkg and gdr_update.
//
// Load, read and unused requests are taken one per cycle while busy is low, and
// their result strobes on out_valid in the next cycle; the receiver cannot stall,
// so results must be taken as they appear. A run request with a nonzero sweep
// count holds busy high for all its sweeps: each interior cell costs four reads
// of the single field store port plus the three stages of the update pipeline,
// and each edge or corner cell reads its operands from the same port and then
// writes it. The result of a run strobes in the cycle busy falls.
module grid_diffusion_relaxation #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64,
  parameter int VALUE_BITS = 32,
  localparam int AW = $clog2(MAX_WIDTH * MAX_HEIGHT)
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic [1:0]                       in_req_type,
  input  logic [AW-1:0]                    in_cell_index,
  input  logic signed [VALUE_BITS-1:0]     in_source_value,
  input  logic signed [VALUE_BITS-1:0]     in_start_value,
  output logic                             out_valid,
  output logic signed [VALUE_BITS-1:0]     out_cell_value,
  output logic                             out_status,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [gdr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [gdr_pkg::CFG_DATA_W-1:0]   cfg_data
);
  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int HW    = $clog2(MAX_HEIGHT + 1);
  localparam int VB    = VALUE_BITS;
  localparam logic signed [VB-1:0] V_MAX = signed'({1'b0, {(VB-1){1'b1}}});
  localparam logic signed [VB-1:0] V_MIN = signed'({1'b1, {(VB-1){1'b0}}});

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CELL = 3'b010,
    ST_EDGE = 3'b100
  } state_t;

  typedef enum logic [2:0] {
    EP_TB     = 3'b001,
    EP_LR     = 3'b010,
    EP_CORNER = 3'b100
  } edge_phase_t;

  state_t      state_r;
  edge_phase_t eph_r;

  logic [31:0] coef_a_r;
  logic [16:0] coef_recip_r;
  logic [6:0]  sweep_count_r, grid_width_r, grid_height_r;
  logic [1:0]  boundary_mode_r;

  logic [WW-1:0] w_c, col_r;
  logic [HW-1:0] h_c, row_r;
  logic [AW-1:0] wa, last, c_r, rb_r;
  logic [AW:0]   area;
  logic [6:0]    n_c, sweep_r;
  logic [16:0]   rc_c;
  logic [2:0]    step_r;
  logic          sub_r;
  logic [1:0]    corner_r;

  logic signed [VB-1:0] fld_mem [DEPTH];
  logic signed [VB-1:0] src_mem [DEPTH];
  logic signed [VB-1:0] fld_rd_r, src_rd_r, pv_r;
  logic signed [VB+1:0] acc_r;

  logic                 fld_we;
  logic [AW-1:0]        fld_waddr, fld_raddr;
  logic signed [VB-1:0] fld_wdata;

  logic [AW-1:0]        e_dst, e_p, e_q;
  logic                 e_neg, e_mean;
  logic signed [VB:0]   e_sum;
  logic signed [VB-1:0] e_val;

  logic                 acc_start, in_grid, load_we;
  logic                 upd_in_valid, upd_out_valid;
  logic signed [VB-1:0] upd_value;
  gdr_pkg::coef_t       coef;

  logic out_valid_r, out_status_r, out_sel_r;

  // Effective grid size, sweep count and reciprocal after range limiting.
  always_comb begin
    if (32'(grid_width_r) > MAX_WIDTH) begin
      w_c = WW'(MAX_WIDTH);
    end else if (grid_width_r < 7'd3) begin
      w_c = WW'(3);
    end else begin
      w_c = WW'(grid_width_r);
    end
    if (32'(grid_height_r) > MAX_HEIGHT) begin
      h_c = HW'(MAX_HEIGHT);
    end else if (grid_height_r < 7'd3) begin
      h_c = HW'(3);
    end else begin
      h_c = HW'(grid_height_r);
    end
  end

  assign n_c  = (sweep_count_r > 7'(gdr_pkg::MAX_SWEEPS)) ? 7'(gdr_pkg::MAX_SWEEPS)
                                                          : sweep_count_r;
  assign rc_c = (coef_recip_r > 17'd65536) ? 17'd65536 : coef_recip_r;
  assign wa   = AW'(w_c);
  assign last = AW'(AW'(h_c - HW'(1)) * wa);
  assign area = (AW+1)'(h_c) * (AW+1)'(w_c);

  assign busy      = (state_r != ST_IDLE);
  assign acc_start = start && !busy;
  assign in_grid   = ({1'b0, in_cell_index} < area);
  assign load_we   = acc_start && (in_req_type == gdr_pkg::REQ_LOAD) && in_grid;
  assign cfg_ready = 1'b1;

  assign coef.a  = coef_a_r;
  assign coef.rc = rc_c;

  // Addresses and operation of the current edge or corner cell.
  always_comb begin
    e_dst  = '0;
    e_p    = '0;
    e_q    = '0;
    e_neg  = 1'b0;
    e_mean = 1'b0;
    case (eph_r)
      EP_TB: begin
        e_neg = (boundary_mode_r == gdr_pkg::MODE_NEG_TB);
        if (sub_r) begin
          e_dst = AW'(col_r) + last;
          e_p   = AW'(col_r) + last - wa;
        end else begin
          e_dst = AW'(col_r);
          e_p   = AW'(col_r) + wa;
        end
        e_q = e_p;
      end
      EP_LR: begin
        e_neg = (boundary_mode_r == gdr_pkg::MODE_NEG_LR);
        if (sub_r) begin
          e_dst = rb_r + wa - AW'(1);
          e_p   = rb_r + wa - AW'(2);
        end else begin
          e_dst = rb_r;
          e_p   = rb_r + AW'(1);
        end
        e_q = e_p;
      end
      EP_CORNER: begin
        e_mean = 1'b1;
        case (corner_r)
          2'd0: begin
            e_dst = '0;
            e_p   = AW'(1);
            e_q   = wa;
          end
          2'd1: begin
            e_dst = last;
            e_p   = last + AW'(1);
            e_q   = last - wa;
          end
          2'd2: begin
            e_dst = wa - AW'(1);
            e_p   = wa - AW'(2);
            e_q   = wa + wa - AW'(1);
          end
          default: begin
            e_dst = last + wa - AW'(1);
            e_p   = last + wa - AW'(2);
            e_q   = last - AW'(1);
          end
        endcase
      end
      default: begin
        e_dst = '0;
      end
    endcase
  end

  // The second operand arrives straight from the store in the write cycle.
  assign e_sum = (VB+1)'(pv_r) + (VB+1)'(fld_rd_r);
  always_comb begin
    if (e_mean) begin
      e_val = VB'(e_sum >>> 1);
    end else if (e_neg) begin
      e_val = (pv_r == V_MIN) ? V_MAX : -pv_r;
    end else begin
      e_val = pv_r;
    end
  end

  // Field store port selection.
  always_comb begin
    fld_raddr = in_cell_index;
    fld_we    = load_we;
    fld_waddr = in_cell_index;
    fld_wdata = in_start_value;
    case (state_r)
      ST_CELL: begin
        case (step_r)
          3'd0:    fld_raddr = c_r - AW'(1);
          3'd1:    fld_raddr = c_r + AW'(1);
          3'd2:    fld_raddr = c_r - wa;
          default: fld_raddr = c_r + wa;
        endcase
        fld_we    = upd_out_valid;
        fld_waddr = c_r;
        fld_wdata = upd_value;
      end
      ST_EDGE: begin
        fld_raddr = (step_r == 3'd0) ? e_p : e_q;
        fld_we    = (step_r == 3'd2);
        fld_waddr = e_dst;
        fld_wdata = e_val;
      end
      default: begin
        fld_we = load_we;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (fld_we) begin
      fld_mem[fld_waddr] <= fld_wdata;
    end
    fld_rd_r <= fld_mem[fld_raddr];
  end

  always_ff @(posedge clk) begin
    if (load_we) begin
      src_mem[in_cell_index] <= in_source_value;
    end
    src_rd_r <= src_mem[c_r];
  end

  assign upd_in_valid = (state_r == ST_CELL) && (step_r == 3'd5);

  gdr_update #(
    .VALUE_BITS (VALUE_BITS)
  ) u_update (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (upd_in_valid),
    .in_sum    (acc_r),
    .in_src    (src_rd_r),
    .coef      (coef),
    .out_valid (upd_out_valid),
    .out_value (upd_value)
  );

  // Neighbor sum and edge operand capture.
  always_ff @(posedge clk) begin
    if (state_r == ST_CELL) begin
      if (step_r == 3'd1) begin
        acc_r <= (VB+2)'(fld_rd_r);
      end else if (step_r == 3'd2 || step_r == 3'd3 || step_r == 3'd4) begin
        acc_r <= acc_r + (VB+2)'(fld_rd_r);
      end
    end
    if (state_r == ST_EDGE && step_r == 3'd1) begin
      pv_r <= fld_rd_r;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_a_r        <= 32'd65536;
      coef_recip_r    <= 17'd13107;
      sweep_count_r   <= 7'd20;
      boundary_mode_r <= 2'd0;
      grid_width_r    <= 7'd64;
      grid_height_r   <= 7'd64;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        gdr_pkg::REG_COEF_A:     coef_a_r        <= cfg_data;
        gdr_pkg::REG_COEF_RECIP: coef_recip_r    <= cfg_data[16:0];
        gdr_pkg::REG_SWEEPS:     sweep_count_r   <= cfg_data[6:0];
        gdr_pkg::REG_MODE:       boundary_mode_r <= cfg_data[1:0];
        gdr_pkg::REG_WIDTH:      grid_width_r    <= cfg_data[6:0];
        gdr_pkg::REG_HEIGHT:     grid_height_r   <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // Request handling and sweep sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      eph_r        <= EP_TB;
      step_r       <= '0;
      sub_r        <= 1'b0;
      corner_r     <= '0;
      sweep_r      <= '0;
      col_r        <= '0;
      row_r        <= '0;
      c_r          <= '0;
      rb_r         <= '0;
      out_valid_r  <= 1'b0;
      out_status_r <= 1'b0;
      out_sel_r    <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (acc_start) begin
            out_status_r <= 1'b0;
            out_sel_r    <= 1'b0;
            case (in_req_type)
              gdr_pkg::REQ_LOAD: begin
                out_valid_r  <= 1'b1;
                out_status_r <= !in_grid;
              end
              gdr_pkg::REQ_READ: begin
                out_valid_r  <= 1'b1;
                out_status_r <= !in_grid;
                out_sel_r    <= in_grid;
              end
              gdr_pkg::REQ_RUN: begin
                if (n_c == '0) begin
                  out_valid_r <= 1'b1;
                end else begin
                  state_r <= ST_CELL;
                  sweep_r <= '0;
                  col_r   <= WW'(1);
                  row_r   <= HW'(1);
                  c_r     <= wa + AW'(1);
                  step_r  <= '0;
                end
              end
              default: begin
                out_valid_r <= 1'b1;
              end
            endcase
          end
        end
        ST_CELL: begin
          if (step_r != 3'd6) begin
            step_r <= step_r + 3'd1;
          end else if (upd_out_valid) begin
            step_r <= '0;
            if (col_r < w_c - WW'(2)) begin
              col_r <= col_r + WW'(1);
              c_r   <= c_r + AW'(1);
            end else if (row_r < h_c - HW'(2)) begin
              row_r <= row_r + HW'(1);
              col_r <= WW'(1);
              c_r   <= c_r + AW'(3);
            end else begin
              state_r <= ST_EDGE;
              eph_r   <= EP_TB;
              col_r   <= WW'(1);
              sub_r   <= 1'b0;
            end
          end
        end
        ST_EDGE: begin
          if (step_r != 3'd2) begin
            step_r <= step_r + 3'd1;
          end else begin
            step_r <= '0;
            case (eph_r)
              EP_TB: begin
                sub_r <= !sub_r;
                if (sub_r) begin
                  if (col_r < w_c - WW'(2)) begin
                    col_r <= col_r + WW'(1);
                  end else begin
                    eph_r <= EP_LR;
                    row_r <= HW'(1);
                    rb_r  <= wa;
                  end
                end
              end
              EP_LR: begin
                sub_r <= !sub_r;
                if (sub_r) begin
                  if (row_r < h_c - HW'(2)) begin
                    row_r <= row_r + HW'(1);
                    rb_r  <= rb_r + wa;
                  end else begin
                    eph_r    <= EP_CORNER;
                    corner_r <= '0;
                  end
                end
              end
              default: begin
                if (corner_r != 2'd3) begin
                  corner_r <= corner_r + 2'd1;
                end else if (sweep_r + 7'd1 == n_c) begin
                  state_r      <= ST_IDLE;
                  out_valid_r  <= 1'b1;
                  out_status_r <= 1'b0;
                  out_sel_r    <= 1'b0;
                end else begin
                  sweep_r <= sweep_r + 7'd1;
                  state_r <= ST_CELL;
                  col_r   <= WW'(1);
                  row_r   <= HW'(1);
                  c_r     <= wa + AW'(1);
                end
              end
            endcase
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_cell_value = out_sel_r ? fld_rd_r : '0;

endmodule

// File: hdl/gdr_update.sv
// Three-stage arithmetic pipeline for one interior cell update.
// Depends on gdr_pkg for the coefficient struct and fixed-point constants.
module gdr_update #(
  parameter int VALUE_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic signed [VALUE_BITS+1:0] in_sum,
  input  logic signed [VALUE_BITS-1:0] in_src,
  input  gdr_pkg::coef_t               coef,
  output logic                         out_valid,
  output logic signed [VALUE_BITS-1:0] out_value
);
  localparam int SW = VALUE_BITS + 2;
  localparam int PW = SW + 17;
  localparam int NW = (VALUE_BITS + 20 > 49) ? VALUE_BITS + 20 : 49;
  localparam int NB = gdr_pkg::NUM_BITS;
  localparam int RB = NB + 18;
  localparam logic signed [NW-1:0] NUM_HI = signed'(NW'({1'b0, {(NB-1){1'b1}}}));
  localparam logic signed [NW-1:0] NUM_LO = -NUM_HI - 1;
  localparam logic signed [RB-1:0] VAL_HI = signed'(RB'({1'b0, {(VALUE_BITS-1){1'b1}}}));
  localparam logic signed [RB-1:0] VAL_LO = -VAL_HI - 1;

  logic signed [16:0]           a_hi, a_lo;
  logic signed [17:0]           rc_s;
  logic signed [PW-1:0]         phi_r, plo_r;
  logic signed [VALUE_BITS-1:0] src_r;
  logic signed [NW-1:0]         num_w;
  logic signed [NB-1:0]         num_r;
  logic signed [RB-1:0]         prod_r, rnd;
  logic                         v1_r, v2_r, v3_r;

  assign a_hi = signed'({1'b0, coef.a[31:16]});
  assign a_lo = signed'({1'b0, coef.a[15:0]});
  assign rc_s = signed'({1'b0, coef.rc});

  // The fractional half of the coefficient product is floored before the sum.
  assign num_w = NW'(src_r) + NW'(phi_r) + NW'(plo_r >>> gdr_pkg::FRAC_BITS);
  assign rnd   = (prod_r + signed'(RB'(32768))) >>> gdr_pkg::FRAC_BITS;

  always_ff @(posedge clk) begin
    phi_r <= a_hi * in_sum;
    plo_r <= a_lo * in_sum;
    src_r <= in_src;
    if (num_w > NUM_HI) begin
      num_r <= NB'(NUM_HI);
    end else if (num_w < NUM_LO) begin
      num_r <= NB'(NUM_LO);
    end else begin
      num_r <= NB'(num_w);
    end
    prod_r <= num_r * rc_s;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  assign out_valid = v3_r;
  assign out_value = (rnd > VAL_HI) ? VALUE_BITS'(VAL_HI) :
                     (rnd < VAL_LO) ? VALUE_BITS'(VAL_LO) : VALUE_BITS'(rnd);

endmodule

// File: hdl/gdr_checker.sv
// Port-level checker for the grid diffusion relaxation block, bound to the top level.
// Depends on gdr_pkg and grid_diffusion_relaxation_macros.svh.
`include "grid_diffusion_relaxation_macros.svh"

module gdr_checker #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64,
  parameter int VALUE_BITS = 32,
  localparam int AW = $clog2(MAX_WIDTH * MAX_HEIGHT)
) (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           start,
  input logic                           busy,
  input logic [1:0]                     in_req_type,
  input logic [AW-1:0]                  in_cell_index,
  input logic [VALUE_BITS-1:0]          in_source_value,
  input logic [VALUE_BITS-1:0]          in_start_value,
  input logic                           out_valid,
  input logic [VALUE_BITS-1:0]          out_cell_value,
  input logic                           out_status,
  input logic                           cfg_valid,
  input logic                           cfg_ready,
  input logic [gdr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input logic [gdr_pkg::CFG_DATA_W-1:0] cfg_data
);

  // Every transfer other than a run is answered in the next cycle.
  `GDR_ASSERT_NEXT(a_quick_result, start && !busy && in_req_type != gdr_pkg::REQ_RUN, out_valid && !busy)

  // A run either finishes at once or keeps the block busy.
  `GDR_ASSERT_NEXT(a_run_busy, start && !busy && in_req_type == gdr_pkg::REQ_RUN, busy || out_valid)

  // A finished run delivers its result as busy drops.
  `GDR_ASSERT_NOW(a_run_done, $fell(busy), out_valid && !out_status && out_cell_value == '0)

  // A rejected index never carries data.
  `GDR_ASSERT_NOW(a_bad_index_zero, out_valid && out_status, out_cell_value == '0)

  // No result appears while a run is still in progress.
  `GDR_ASSERT_NOW(a_quiet_while_busy, busy, !out_valid)

endmodule

bind grid_diffusion_relaxation gdr_checker #(
  .MAX_WIDTH  (MAX_WIDTH),
  .MAX_HEIGHT (MAX_HEIGHT),
  .VALUE_BITS (VALUE_BITS)
) u_gdr_checker (.*);

// File: tb/tb_grid_diffusion_relaxation.sv
// Self-checking testbench for grid_diffusion_relaxation: loads, reads and relaxation runs.
// Depends on gdr_pkg and the RTL; predicts every result with its own copy of the grids.
`timescale 1ns / 100ps

module tb_grid_diffusion_relaxation;

  localparam logic [1:0] REQ_SPARE  = 2'd3;
  localparam logic [1:0] MODE_COPY  = 2'd0;
  localparam logic [1:0] MODE_SPARE = 2'd3;
  localparam int CELLS = 4096;
  localparam longint CYCLE_LIMIT = 3000000;

  typedef struct {
    logic [1:0]         kind;
    logic [11:0]        idx;
    logic signed [31:0] src;
    logic signed [31:0] fld;
  } cell_req_t;

  typedef struct {
    logic signed [31:0] value;
    logic               status;
  } cell_resp_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] in_req_type = '0;
  logic [11:0] in_cell_index = '0;
  logic signed [31:0] in_source_value = '0;
  logic signed [31:0] in_start_value = '0;
  logic out_valid;
  logic signed [31:0] out_cell_value;
  logic out_status;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [gdr_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [gdr_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  grid_diffusion_relaxation u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_req_type(in_req_type), .in_cell_index(in_cell_index),
    .in_source_value(in_source_value), .in_start_value(in_start_value),
    .out_valid(out_valid), .out_cell_value(out_cell_value), .out_status(out_status),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  // Predictor state.
  logic signed [31:0] src_grid [CELLS];
  logic signed [31:0] fld_grid [CELLS];
  logic [31:0] diff_a = 32'd65536;
  logic [16:0] recip = 17'd13107;
  logic [6:0]  sweeps = 7'd20;
  logic [1:0]  bmode = MODE_COPY;
  logic [6:0]  gw_raw = 7'd64;
  logic [6:0]  gh_raw = 7'd64;

  cell_req_t  pending_reqs[$];
  cell_resp_t expected_resps[$];
  int errors = 0;
  int idle_pct = 8;
  int runs_done = 0;
  int reads_checked = 0;
  longint cycles = 0;

  function automatic int eff_dim(logic [6:0] raw);
    return raw < 3 ? 3 : (raw > 64 ? 64 : int'(raw));
  endfunction

  function automatic logic signed [31:0] sat32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] edge_val(logic signed [31:0] v, bit neg);
    return neg ? sat32(-longint'(v)) : v;
  endfunction

  function automatic logic signed [31:0] corner_mean(logic signed [31:0] p,
                                                     logic signed [31:0] q);
    longint s;
    s = (longint'(p) + longint'(q)) >>> 1;
    return s[31:0];
  endfunction

  task automatic relax_grid();
    int w, h, n, c, last;
    longint a_hi, a_lo, rc, d, num;
    bit neg_tb, neg_lr;
    w = eff_dim(gw_raw);
    h = eff_dim(gh_raw);
    n = sweeps > 64 ? 64 : int'(sweeps);
    a_hi = longint'(diff_a[31:16]);
    a_lo = longint'(diff_a[15:0]);
    rc = recip > 17'd65536 ? 65536 : longint'(recip);
    neg_tb = (bmode == gdr_pkg::MODE_NEG_TB);
    neg_lr = (bmode == gdr_pkg::MODE_NEG_LR);
    last = (h - 1) * w;
    for (int k = 0; k < n; k++) begin
      for (int j = 1; j < h - 1; j++) begin
        for (int i = 1; i < w - 1; i++) begin
          c = j * w + i;
          d = longint'(fld_grid[c-1]) + longint'(fld_grid[c+1])
            + longint'(fld_grid[c-w]) + longint'(fld_grid[c+w]);
          num = longint'(src_grid[c]) + a_hi * d + ((a_lo * d) >>> 16);
          if (num > (64'sd1 <<< 47) - 1) num = (64'sd1 <<< 47) - 1;
          if (num < -(64'sd1 <<< 47)) num = -(64'sd1 <<< 47);
          fld_grid[c] = sat32((num * rc + 32768) >>> 16);
        end
      end
      for (int i = 1; i < w - 1; i++) begin
        fld_grid[i] = edge_val(fld_grid[i+w], neg_tb);
        fld_grid[i+last] = edge_val(fld_grid[i+last-w], neg_tb);
      end
      for (int j = 1; j < h - 1; j++) begin
        fld_grid[j*w] = edge_val(fld_grid[j*w+1], neg_lr);
        fld_grid[j*w+w-1] = edge_val(fld_grid[j*w+w-2], neg_lr);
      end
      fld_grid[0] = corner_mean(fld_grid[1], fld_grid[w]);
      fld_grid[last] = corner_mean(fld_grid[last+1], fld_grid[last-w]);
      fld_grid[w-1] = corner_mean(fld_grid[w-2], fld_grid[2*w-1]);
      fld_grid[last+w-1] = corner_mean(fld_grid[last+w-2], fld_grid[last-1]);
    end
  endtask

  task automatic predict_cell(input cell_req_t rq, output cell_resp_t rs);
    bit in_grid;
    in_grid = int'(rq.idx) < eff_dim(gw_raw) * eff_dim(gh_raw);
    rs.value = '0;
    rs.status = 1'b0;
    case (rq.kind)
      gdr_pkg::REQ_LOAD, gdr_pkg::REQ_READ: begin
        if (!in_grid) begin
          rs.status = 1'b1;
        end else if (rq.kind == gdr_pkg::REQ_LOAD) begin
          src_grid[rq.idx] = rq.src;
          fld_grid[rq.idx] = rq.fld;
        end else begin
          rs.value = fld_grid[rq.idx];
        end
      end
      gdr_pkg::REQ_RUN: relax_grid();
      default: ;
    endcase
  endtask

  task automatic report(input string what, input longint got, input longint want);
    $display("[%0t] %s: got %0d, expected %0d", $time, what, got, want);
    errors++;
  endtask

  // Driver: presents the head of the queue, idling at random.
  always @(negedge clk) begin
    if (rst_n && pending_reqs.size() > 0 && $urandom_range(99) >= idle_pct) begin
      start <= 1'b1;
      in_req_type <= pending_reqs[0].kind;
      in_cell_index <= pending_reqs[0].idx;
      in_source_value <= pending_reqs[0].src;
      in_start_value <= pending_reqs[0].fld;
    end else begin
      start <= 1'b0;
    end
  end

  // Monitor: checks results, then records the transfer of a new request.
  always @(posedge clk) begin
    cell_req_t rq;
    cell_resp_t rs;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("grid_diffusion_relaxation: mismatch");
      $finish;
    end else if (rst_n) begin
      if (out_valid) begin
        if (expected_resps.size() == 0) begin
          report("unexpected result", out_cell_value, 0);
        end else begin
          rs = expected_resps.pop_front();
          if (out_cell_value !== rs.value) report("cell_value", out_cell_value, rs.value);
          if (out_status !== rs.status) report("status", out_status, rs.status);
        end
      end
      if (start && !busy) begin
        rq = pending_reqs.pop_front();
        predict_cell(rq, rs);
        expected_resps.push_back(rs);
        if (rq.kind == gdr_pkg::REQ_RUN) runs_done++;
        if (rq.kind == gdr_pkg::REQ_READ) reads_checked++;
      end
    end
  end

  function automatic logic signed [31:0] rand_value();
    case ($urandom_range(4))
      0: return $urandom;
      1: return $signed($urandom_range(8 << 16)) - (4 << 16);
      2: return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
      default: return $signed($urandom_range(2000 << 16)) - (1000 << 16);
    endcase
  endfunction

  task automatic push_req(logic [1:0] kind, int idx,
                          logic signed [31:0] s, logic signed [31:0] f);
    cell_req_t rq;
    rq.kind = kind;
    rq.idx = 12'(idx);
    rq.src = s;
    rq.fld = f;
    pending_reqs.push_back(rq);
  endtask

  task automatic drain();
    wait (pending_reqs.size() == 0 && expected_resps.size() == 0 && !busy);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [gdr_pkg::CFG_IDX_W-1:0] idx, logic [31:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      gdr_pkg::REG_COEF_A:     diff_a = data;
      gdr_pkg::REG_COEF_RECIP: recip = data[16:0];
      gdr_pkg::REG_SWEEPS:     sweeps = data[6:0];
      gdr_pkg::REG_MODE:       bmode = data[1:0];
      gdr_pkg::REG_WIDTH:      gw_raw = data[6:0];
      gdr_pkg::REG_HEIGHT:     gh_raw = data[6:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic setup(logic [31:0] a, logic [31:0] rc, logic [31:0] sw,
                       logic [31:0] md, logic [31:0] w, logic [31:0] h);
    drain();
    write_reg(gdr_pkg::REG_COEF_A, a);
    write_reg(gdr_pkg::REG_COEF_RECIP, rc);
    write_reg(gdr_pkg::REG_SWEEPS, sw);
    write_reg(gdr_pkg::REG_MODE, md);
    write_reg(gdr_pkg::REG_WIDTH, w);
    write_reg(gdr_pkg::REG_HEIGHT, h);
  endtask

  // Every cell of the grid in use is loaded, so runs and reads never touch an unwritten cell.
  task automatic fill_grid();
    for (int c = 0; c < eff_dim(gw_raw) * eff_dim(gh_raw); c++)
      push_req(gdr_pkg::REQ_LOAD, c, rand_value(), rand_value());
  endtask

  task automatic random_ops(int n);
    int cells, r;
    cells = eff_dim(gw_raw) * eff_dim(gh_raw);
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(99);
      if (r < 45) begin
        push_req(gdr_pkg::REQ_LOAD, $urandom_range(cells - 1), rand_value(), rand_value());
      end else if (r < 85) begin
        push_req(gdr_pkg::REQ_READ, $urandom_range(cells - 1), $urandom, $urandom);
      end else if (r < 91 && cells < CELLS) begin
        push_req($urandom_range(1) ? gdr_pkg::REQ_LOAD : gdr_pkg::REQ_READ,
                 $urandom_range(CELLS - 1, cells), $urandom, $urandom);
      end else if (r < 95) begin
        push_req(REQ_SPARE, $urandom, $urandom, $urandom);
      end else begin
        push_req(gdr_pkg::REQ_RUN, $urandom, $urandom, $urandom);
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: a 4 x 3 grid with extreme values, out-of-grid and unused requests.
    setup(32'd65536, 32'd13107, 32'd3, 32'(MODE_COPY), 32'd4, 32'd3);
    push_req(gdr_pkg::REQ_LOAD, 0, 32'sh7fffffff, 32'sh80000000);
    push_req(gdr_pkg::REQ_LOAD, 1, 32'sh80000000, 32'sh7fffffff);
    for (int c = 2; c < 12; c++) push_req(gdr_pkg::REQ_LOAD, c, rand_value(), rand_value());
    push_req(gdr_pkg::REQ_READ, 0, '0, '0);
    push_req(gdr_pkg::REQ_LOAD, 4095, 32'shffffffff, 32'shffffffff);
    push_req(gdr_pkg::REQ_READ, 4095, '0, '0);
    push_req(REQ_SPARE, 5, '0, '0);
    push_req(gdr_pkg::REQ_RUN, 0, '0, '0);
    for (int c = 0; c < 12; c += 3) push_req(gdr_pkg::REQ_READ, c, '0, '0);

    // Extreme settings: no sweeps, clamped sizes, saturated reciprocal and counts.
    setup(32'd0, 32'd65536, 32'd0, 32'(gdr_pkg::MODE_NEG_LR), 32'd2, 32'd5);
    fill_grid();
    random_ops(30);
    setup(32'hffffffff, 32'd0, 32'd127, 32'(gdr_pkg::MODE_NEG_TB), 32'd3, 32'd3);
    fill_grid();
    random_ops(30);
    setup($urandom, 32'h1ffff, 32'd5, 32'(MODE_SPARE), 32'd8, 32'd6);
    fill_grid();
    random_ops(40);
    setup(32'd32768, 32'd32768, 32'd10, 32'(gdr_pkg::MODE_NEG_LR), 32'd127, 32'd0);
    fill_grid();
    random_ops(40);
    setup(32'd65536, 32'd13107, 32'd1, 32'(gdr_pkg::MODE_NEG_TB), 32'd16, 32'd8);
    fill_grid();
    random_ops(40);

    for (int ph = 0; ph < 10; ph++) begin
      idle_pct = ph < 4 ? 8 : (ph < 7 ? 61 : 0);
      setup($urandom_range(1) ? $urandom_range(4 << 16) : $urandom,
            $urandom_range(9) == 0 ? $urandom_range(131071) : $urandom_range(65536),
            $urandom_range(16, 1), $urandom_range(3),
            $urandom_range(8, 3), $urandom_range(8, 3));
      fill_grid();
      random_ops(25);
    end

    drain();
    repeat (20) @(posedge clk);
    $display("Covered loads, reads, %0d relaxation runs and %0d checked reads", runs_done,
             reads_checked);
    $display("across clamped, saturated and random settings in %0d cycles.", cycles);
    if (errors == 0) begin
      $display("grid_diffusion_relaxation: match");
    end else begin
      $display("grid_diffusion_relaxation: mismatch");
    end
    $finish;
  end

endmodule
